@@ hw/rtl/e2cd_pkg.sv @@
package e2cd_pkg;

    localparam int SECONDS_WIDTH_DEFAULT = 40;

    // Widths of the result fields.
    localparam int YEAR_W    = 16;
    localparam int MONTH_W   = 4;
    localparam int MDAY_W    = 5;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;
    localparam int WEEKDAY_W = 3;
    localparam int YDAY_W    = 9;

    // Internal widths.
    localparam int EDAY_W  = 18;  // day of era, 0 .. 146096
    localparam int TOD_W   = 17;  // second of day, 0 .. 86399
    localparam int DR_W    = 10;  // remainder modulo 675
    localparam int EYEAR_W = 9;   // year of era, 0 .. 399
    localparam int MP_W    = 4;   // March-based month, 0 .. 11
    localparam int MPN_W   = 11;  // 5 * day of March-based year + 2

    // One day is 128 * 675 seconds; the low seven bits bypass the division.
    localparam int DAY_SHIFT = 7;
    localparam int DAY_UNITS = 675;

    // Seconds from 0000-03-01 to 1970-01-01 (719468 days).
    localparam int OFFSET_W = 36;
    localparam longint unsigned MARCH_OFFSET_SECONDS = 64'd62162035200;

    // One 400-year era in units of 128 seconds (146097 * 675).
    localparam int REM_W = 27;
    localparam logic [REM_W-1:0] ERA_DIVISOR = 27'd98615475;
    localparam int ERA_LOW_W = 12;
    localparam int STEPS_PER_STAGE = 2;

    localparam int ERA_YEARS     = 400;
    localparam int WEEK_DAYS     = 7;
    localparam int WEEKDAY_BASE  = 3;
    localparam int YEAR_DAYS     = 365;
    localparam int HOUR_SECONDS  = 3600;
    localparam int MINUTE_SECONDS = 60;

    localparam logic [EYEAR_W-1:0] CENTURY_1 = 9'd100;
    localparam logic [EYEAR_W-1:0] CENTURY_2 = 9'd200;
    localparam logic [EYEAR_W-1:0] CENTURY_3 = 9'd300;

    localparam logic [MP_W-1:0]   JANUARY_MP     = 4'd10;
    localparam logic [MONTH_W-1:0] MARCH_MONTH   = 4'd2;
    localparam logic [YDAY_W-1:0] JANUARY_1_YDAY = 9'd306;
    localparam logic [YDAY_W-1:0] JAN_FEB_DAYS   = 9'd59;

    // Reciprocals: q = (n * M) >> S is exact for every n of the given width.
    localparam int DIV675_S    = 37;
    localparam int DIV1460_S   = 29;
    localparam int DIV36524_S  = 34;
    localparam int DIV146096_S = 36;
    localparam int DIV7_S      = 21;
    localparam int DIV3600_S   = 29;
    localparam int DIV60_S     = 23;
    localparam int DIV365_S    = 27;
    localparam int DIV100_S    = 16;
    localparam int DIV153_S    = 19;

    localparam logic [REM_W:0] DIV675_M =
        (REM_W+1)'(((64'd1 << DIV675_S) + 64'd674) / 64'd675);
    localparam logic [EDAY_W:0] DIV1460_M =
        (EDAY_W+1)'(((64'd1 << DIV1460_S) + 64'd1459) / 64'd1460);
    localparam logic [EDAY_W:0] DIV36524_M =
        (EDAY_W+1)'(((64'd1 << DIV36524_S) + 64'd36523) / 64'd36524);
    localparam logic [EDAY_W:0] DIV146096_M =
        (EDAY_W+1)'(((64'd1 << DIV146096_S) + 64'd146095) / 64'd146096);
    localparam logic [EDAY_W:0] DIV7_M =
        (EDAY_W+1)'(((64'd1 << DIV7_S) + 64'd6) / 64'd7);
    localparam logic [TOD_W:0] DIV3600_M =
        (TOD_W+1)'(((64'd1 << DIV3600_S) + 64'd3599) / 64'd3600);
    localparam logic [TOD_W:0] DIV60_M =
        (TOD_W+1)'(((64'd1 << DIV60_S) + 64'd59) / 64'd60);
    localparam logic [EDAY_W:0] DIV365_M =
        (EDAY_W+1)'(((64'd1 << DIV365_S) + 64'd364) / 64'd365);
    localparam logic [EYEAR_W:0] DIV100_M =
        (EYEAR_W+1)'(((64'd1 << DIV100_S) + 64'd99) / 64'd100);
    localparam logic [MPN_W:0] DIV153_M =
        (MPN_W+1)'(((64'd1 << DIV153_S) + 64'd152) / 64'd153);

    typedef struct packed {
        logic [YEAR_W-1:0]    year;
        logic [MONTH_W-1:0]   month;
        logic [MDAY_W-1:0]    day_of_month;
        logic [HOUR_W-1:0]    hour;
        logic [MINUTE_W-1:0]  minute;
        logic [SECOND_W-1:0]  second;
        logic [WEEKDAY_W-1:0] weekday;
        logic [YDAY_W-1:0]    day_of_year;
    } result_t;

endpackage

@@ hw/rtl/epoch_seconds_to_civil_date.sv @@
// Converts signed seconds since 1970-01-01 00:00:00 UTC into the proleptic
// Gregorian date and time of day: year, month, day of month, hour, minute,
// second, weekday and day of year.
// The input channel (s_valid, s_ready, s_epoch_seconds) takes one word per
// cycle while s_ready is high. The input is SECONDS_WIDTH-bit two's complement.
// The result channel (m_valid, m_ready, m_*) delivers one word for each input
// word, in order.
// The era divider performs N = max(SECONDS_WIDTH, 36) - 33 restoring steps,
// two per stage. Throughput is one word per cycle while the receiver does not
// stall; all other divisions are by constants and run as reciprocal
// multiplications.
// A skid register behind the output register absorbs one word when the
// receiver stalls; the pipeline then holds and s_ready drops until the skid
// register drains, so no word is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and the output; the
// block holds no other state.
module epoch_seconds_to_civil_date #(
    parameter int SECONDS_WIDTH = e2cd_pkg::SECONDS_WIDTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [SECONDS_WIDTH-1:0] s_epoch_seconds,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [e2cd_pkg::YEAR_W-1:0]    m_year,
    output logic        [e2cd_pkg::MONTH_W-1:0]   m_month,
    output logic        [e2cd_pkg::MDAY_W-1:0]    m_day_of_month,
    output logic        [e2cd_pkg::HOUR_W-1:0]    m_hour,
    output logic        [e2cd_pkg::MINUTE_W-1:0]  m_minute,
    output logic        [e2cd_pkg::SECOND_W-1:0]  m_second,
    output logic        [e2cd_pkg::WEEKDAY_W-1:0] m_weekday,
    output logic        [e2cd_pkg::YDAY_W-1:0]    m_day_of_year
);

    localparam int DS    = e2cd_pkg::DAY_SHIFT;
    localparam int RW    = e2cd_pkg::REM_W;
    localparam int QW    = e2cd_pkg::ERA_LOW_W;
    localparam int SPS   = e2cd_pkg::STEPS_PER_STAGE;
    localparam int XW    = ((SECONDS_WIDTH > e2cd_pkg::OFFSET_W) ?
                            SECONDS_WIDTH : e2cd_pkg::OFFSET_W) + 1;
    localparam int UW    = XW - 1 - DS;
    localparam int NSTEP = UW - (RW - 1);
    localparam int NDIV  = (NSTEP + SPS - 1) / SPS;

    localparam int EW   = e2cd_pkg::EDAY_W;
    localparam int TW   = e2cd_pkg::TOD_W;
    localparam int DRW  = e2cd_pkg::DR_W;
    localparam int YW   = e2cd_pkg::EYEAR_W;
    localparam int MPW  = e2cd_pkg::MP_W;
    localparam int MNW  = e2cd_pkg::MPN_W;
    localparam int YRW  = e2cd_pkg::YEAR_W;
    localparam int DYW  = e2cd_pkg::YDAY_W;
    localparam int HW   = e2cd_pkg::HOUR_W;
    localparam int MIW  = e2cd_pkg::MINUTE_W;
    localparam int SW   = e2cd_pkg::SECOND_W;
    localparam int WDW  = e2cd_pkg::WEEKDAY_W;
    localparam int MOW  = e2cd_pkg::MONTH_W;
    localparam int MDW  = e2cd_pkg::MDAY_W;

    localparam int PW_R = RW + RW + 1;
    localparam int PW_E = EW + EW + 1;
    localparam int PW_T = TW + TW + 1;
    localparam int PW_Y = YW + YW + 1;
    localparam int PW_M = MNW + MNW + 1;

    localparam int A_W   = 7;   // day of era / 1460
    localparam int B_W   = 3;   // day of era / 36524
    localparam int WQ_W  = 15;  // (day of era + 3) / 7
    localparam int MT_W  = 11;  // minute of day
    localparam int C1_W  = 2;   // year of era / 100

    function automatic logic [DYW-1:0] month_start(input logic [MPW-1:0] mp);
        logic [DYW-1:0] d;
        unique case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = '0;
        endcase
        return d;
    endfunction

    logic en;
    logic skid_valid_reg;
    logic m_valid_reg;
    e2cd_pkg::result_t out_reg;
    e2cd_pkg::result_t skid_reg;
    e2cd_pkg::result_t result_next;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // ---------------------------------------------------------------- input
    logic                     st0_valid_reg;
    logic [SECONDS_WIDTH-1:0] st0_t_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_valid_reg <= 1'b0;
        end else if (en) begin
            st0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st0_t_reg <= s_epoch_seconds;
        end
    end

    // ------------------------------------------- shift to a March epoch base
    // For a negative dividend the divider works on its complement; floor
    // quotient and remainder are recovered by inverting afterwards.
    logic [XW-1:0]    x_sum;
    logic             x_neg;
    logic [UW-1:0]    x_mag;

    always_comb begin
        x_sum = {{(XW-SECONDS_WIDTH){st0_t_reg[SECONDS_WIDTH-1]}}, st0_t_reg}
                + XW'(e2cd_pkg::MARCH_OFFSET_SECONDS);
        x_neg = x_sum[XW-1];
        x_mag = x_neg ? ~x_sum[XW-2:DS] : x_sum[XW-2:DS];
    end

    logic             div_valid_reg [NDIV+1];
    logic             div_neg_reg   [NDIV+1];
    logic [DS-1:0]    div_lo_reg    [NDIV+1];
    logic [RW-1:0]    div_rem_reg   [NDIV+1];
    logic [NSTEP-1:0] div_bits_reg  [NDIV+1];
    logic [QW-1:0]    div_q_reg     [NDIV+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_valid_reg[0] <= 1'b0;
        end else if (en) begin
            div_valid_reg[0] <= st0_valid_reg;
        end
    end

    // The top bits are always below the divisor, so they load the remainder.
    always_ff @(posedge aclk) begin
        if (en) begin
            div_neg_reg[0]  <= x_neg;
            div_lo_reg[0]   <= x_sum[DS-1:0];
            div_rem_reg[0]  <= {1'b0, x_mag[UW-1 -: RW-1]};
            div_bits_reg[0] <= x_mag[NSTEP-1:0];
            div_q_reg[0]    <= '0;
        end
    end

    // ------------------------------------- era divider, restoring, 2 bits/stage
    for (genvar k = 0; k < NDIV; k++) begin : g_div
        logic [RW-1:0]    rem_next;
        logic [NSTEP-1:0] bits_next;
        logic [QW-1:0]    q_next;
        logic [RW:0]      trial;

        always_comb begin
            rem_next  = div_rem_reg[k];
            bits_next = div_bits_reg[k];
            q_next    = div_q_reg[k];
            trial     = '0;
            for (int j = 0; j < SPS; j++) begin
                if (k * SPS + j < NSTEP) begin
                    trial     = {rem_next, bits_next[NSTEP-1]};
                    bits_next = bits_next << 1;
                    if (trial >= {1'b0, e2cd_pkg::ERA_DIVISOR}) begin
                        rem_next = RW'(trial - {1'b0, e2cd_pkg::ERA_DIVISOR});
                        q_next   = {q_next[QW-2:0], 1'b1};
                    end else begin
                        rem_next = trial[RW-1:0];
                        q_next   = {q_next[QW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                div_valid_reg[k+1] <= div_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                div_neg_reg[k+1]  <= div_neg_reg[k];
                div_lo_reg[k+1]   <= div_lo_reg[k];
                div_rem_reg[k+1]  <= rem_next;
                div_bits_reg[k+1] <= bits_next;
                div_q_reg[k+1]    <= q_next;
            end
        end
    end

    // ------------------------------------------------ stage 2: floor fix-up
    logic          st2_valid_reg;
    logic [QW-1:0] st2_era_reg;
    logic [RW-1:0] st2_r2m_reg;
    logic [DS-1:0] st2_lo_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            st2_era_reg <= div_neg_reg[NDIV] ? ~div_q_reg[NDIV] : div_q_reg[NDIV];
            st2_r2m_reg <= div_neg_reg[NDIV] ?
                           RW'(e2cd_pkg::ERA_DIVISOR - RW'(1) - div_rem_reg[NDIV]) :
                           div_rem_reg[NDIV];
            st2_lo_reg  <= div_lo_reg[NDIV];
        end
    end

    // -------------------------------------------- stage 3: day of era
    logic            st3_valid_reg;
    logic [EW-1:0]   st3_eday_reg;
    logic [RW-1:0]   st3_r2m_reg;
    logic [DS-1:0]   st3_lo_reg;
    logic [YRW-1:0]  st3_era400_reg;
    logic [PW_R-1:0] st3_prod;

    assign st3_prod = PW_R'(st2_r2m_reg) * PW_R'(e2cd_pkg::DIV675_M);

    always_ff @(posedge aclk) begin
        if (en) begin
            st3_eday_reg   <= st3_prod[e2cd_pkg::DIV675_S +: EW];
            st3_r2m_reg    <= st2_r2m_reg;
            st3_lo_reg     <= st2_lo_reg;
            st3_era400_reg <= YRW'(st2_era_reg) * YRW'(e2cd_pkg::ERA_YEARS);
        end
    end

    // ------------------------ stage 4: time of day, century terms, weekday
    logic            st4_valid_reg;
    logic [TW-1:0]   st4_tod_reg;
    logic [EW-1:0]   st4_eday_reg;
    logic [A_W-1:0]  st4_a_reg;
    logic [B_W-1:0]  st4_b_reg;
    logic            st4_c_reg;
    logic [WQ_W-1:0] st4_wq_reg;
    logic [YRW-1:0]  st4_era400_reg;
    logic [DRW-1:0]  st4_dr;
    logic [PW_E-1:0] st4_a_prod;
    logic [PW_E-1:0] st4_b_prod;
    logic [PW_E-1:0] st4_c_prod;
    logic [PW_E-1:0] st4_w_prod;

    always_comb begin
        st4_dr     = DRW'(st3_r2m_reg - RW'(st3_eday_reg) * RW'(e2cd_pkg::DAY_UNITS));
        st4_a_prod = PW_E'(st3_eday_reg) * PW_E'(e2cd_pkg::DIV1460_M);
        st4_b_prod = PW_E'(st3_eday_reg) * PW_E'(e2cd_pkg::DIV36524_M);
        st4_c_prod = PW_E'(st3_eday_reg) * PW_E'(e2cd_pkg::DIV146096_M);
        st4_w_prod = PW_E'(st3_eday_reg + EW'(e2cd_pkg::WEEKDAY_BASE))
                     * PW_E'(e2cd_pkg::DIV7_M);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st4_tod_reg    <= {st4_dr, st3_lo_reg};
            st4_eday_reg   <= st3_eday_reg;
            st4_a_reg      <= st4_a_prod[e2cd_pkg::DIV1460_S +: A_W];
            st4_b_reg      <= st4_b_prod[e2cd_pkg::DIV36524_S +: B_W];
            st4_c_reg      <= st4_c_prod[e2cd_pkg::DIV146096_S];
            st4_wq_reg     <= st4_w_prod[e2cd_pkg::DIV7_S +: WQ_W];
            st4_era400_reg <= st3_era400_reg;
        end
    end

    // ------------------------------- stage 5: hour, minute of day, year of era
    logic             st5_valid_reg;
    logic [TW-1:0]    st5_tod_reg;
    logic [HW-1:0]    st5_hour_reg;
    logic [MT_W-1:0]  st5_mt_reg;
    logic [WDW-1:0]   st5_weekday_reg;
    logic [EW-1:0]    st5_eday_reg;
    logic [YW-1:0]    st5_eyear_reg;
    logic [YRW-1:0]   st5_era400_reg;
    logic [PW_T-1:0]  st5_h_prod;
    logic [PW_T-1:0]  st5_m_prod;
    logic [EW-1:0]    st5_num;
    logic [PW_E-1:0]  st5_y_prod;

    always_comb begin
        st5_h_prod = PW_T'(st4_tod_reg) * PW_T'(e2cd_pkg::DIV3600_M);
        st5_m_prod = PW_T'(st4_tod_reg) * PW_T'(e2cd_pkg::DIV60_M);
        st5_num    = st4_eday_reg - EW'(st4_a_reg) + EW'(st4_b_reg) - EW'(st4_c_reg);
        st5_y_prod = PW_E'(st5_num) * PW_E'(e2cd_pkg::DIV365_M);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st5_tod_reg     <= st4_tod_reg;
            st5_hour_reg    <= st5_h_prod[e2cd_pkg::DIV3600_S +: HW];
            st5_mt_reg      <= st5_m_prod[e2cd_pkg::DIV60_S +: MT_W];
            st5_weekday_reg <= WDW'(st4_eday_reg + EW'(e2cd_pkg::WEEKDAY_BASE)
                               - EW'(st4_wq_reg) * EW'(e2cd_pkg::WEEK_DAYS));
            st5_eday_reg    <= st4_eday_reg;
            st5_eyear_reg   <= st5_y_prod[e2cd_pkg::DIV365_S +: YW];
            st5_era400_reg  <= st4_era400_reg;
        end
    end

    // ------------------------- stage 6: minute, second, March-based day, leap
    logic            st6_valid_reg;
    logic [HW-1:0]   st6_hour_reg;
    logic [MIW-1:0]  st6_minute_reg;
    logic [SW-1:0]   st6_second_reg;
    logic [WDW-1:0]  st6_weekday_reg;
    logic [DYW-1:0]  st6_yday_reg;
    logic            st6_leap_reg;
    logic [YW-1:0]   st6_eyear_reg;
    logic [YRW-1:0]  st6_era400_reg;
    logic [PW_Y-1:0] st6_c_prod;
    logic [EW-1:0]   st6_ybase;
    logic            st6_leap;

    always_comb begin
        st6_c_prod = PW_Y'(st5_eyear_reg) * PW_Y'(e2cd_pkg::DIV100_M);
        st6_ybase  = EW'(st5_eyear_reg) * EW'(e2cd_pkg::YEAR_DAYS)
                     + EW'(st5_eyear_reg[YW-1:2])
                     - EW'(st6_c_prod[e2cd_pkg::DIV100_S +: C1_W]);
        // Years of the era divisible by 4 leap, except the three
        // centuries that are not multiples of 400.
        st6_leap   = (st5_eyear_reg[1:0] == 2'b00)
                     && (st5_eyear_reg != e2cd_pkg::CENTURY_1)
                     && (st5_eyear_reg != e2cd_pkg::CENTURY_2)
                     && (st5_eyear_reg != e2cd_pkg::CENTURY_3);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st6_hour_reg    <= st5_hour_reg;
            st6_minute_reg  <= MIW'(st5_mt_reg
                               - MT_W'(st5_hour_reg) * MT_W'(e2cd_pkg::MINUTE_SECONDS));
            st6_second_reg  <= SW'(st5_tod_reg
                               - TW'(st5_mt_reg) * TW'(e2cd_pkg::MINUTE_SECONDS));
            st6_weekday_reg <= st5_weekday_reg;
            st6_yday_reg    <= DYW'(st5_eday_reg - st6_ybase);
            st6_leap_reg    <= st6_leap;
            st6_eyear_reg   <= st5_eyear_reg;
            st6_era400_reg  <= st5_era400_reg;
        end
    end

    // --------------------------------------- stage 7: March-based month
    logic            st7_valid_reg;
    logic [HW-1:0]   st7_hour_reg;
    logic [MIW-1:0]  st7_minute_reg;
    logic [SW-1:0]   st7_second_reg;
    logic [WDW-1:0]  st7_weekday_reg;
    logic [DYW-1:0]  st7_yday_reg;
    logic            st7_leap_reg;
    logic [YW-1:0]   st7_eyear_reg;
    logic [YRW-1:0]  st7_era400_reg;
    logic [MPW-1:0]  st7_mp_reg;
    logic [PW_M-1:0] st7_prod;

    assign st7_prod = PW_M'(MNW'(st6_yday_reg) * MNW'(5) + MNW'(2))
                      * PW_M'(e2cd_pkg::DIV153_M);

    always_ff @(posedge aclk) begin
        if (en) begin
            st7_hour_reg    <= st6_hour_reg;
            st7_minute_reg  <= st6_minute_reg;
            st7_second_reg  <= st6_second_reg;
            st7_weekday_reg <= st6_weekday_reg;
            st7_yday_reg    <= st6_yday_reg;
            st7_leap_reg    <= st6_leap_reg;
            st7_eyear_reg   <= st6_eyear_reg;
            st7_era400_reg  <= st6_era400_reg;
            st7_mp_reg      <= st7_prod[e2cd_pkg::DIV153_S +: MPW];
        end
    end

    // Valid bits of stages 2 to 7.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            st5_valid_reg <= 1'b0;
            st6_valid_reg <= 1'b0;
            st7_valid_reg <= 1'b0;
        end else if (en) begin
            st2_valid_reg <= div_valid_reg[NDIV];
            st3_valid_reg <= st2_valid_reg;
            st4_valid_reg <= st3_valid_reg;
            st5_valid_reg <= st4_valid_reg;
            st6_valid_reg <= st5_valid_reg;
            st7_valid_reg <= st6_valid_reg;
        end
    end

    // ------------------------------- final fields: January-based calendar
    always_comb begin
        logic jan_feb;
        jan_feb = (st7_mp_reg >= e2cd_pkg::JANUARY_MP);
        result_next.year         = st7_era400_reg + YRW'(st7_eyear_reg) + YRW'(jan_feb);
        result_next.month        = jan_feb ? MOW'(st7_mp_reg - e2cd_pkg::JANUARY_MP) :
                                             MOW'(st7_mp_reg + e2cd_pkg::MARCH_MONTH);
        result_next.day_of_month = MDW'(st7_yday_reg - month_start(st7_mp_reg) + DYW'(1));
        result_next.hour         = st7_hour_reg;
        result_next.minute       = st7_minute_reg;
        result_next.second       = st7_second_reg;
        result_next.weekday      = st7_weekday_reg;
        result_next.day_of_year  = (st7_yday_reg >= e2cd_pkg::JANUARY_1_YDAY) ?
            DYW'(st7_yday_reg - e2cd_pkg::JANUARY_1_YDAY) :
            DYW'(st7_yday_reg + e2cd_pkg::JAN_FEB_DAYS + DYW'(st7_leap_reg));
    end

    // ------------------------------------ output register and skid register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= st7_valid_reg;
            end
        end else if (st7_valid_reg && en) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : result_next;
        end else if (en) begin
            skid_reg <= result_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_year         = out_reg.year;
    assign m_month        = out_reg.month;
    assign m_day_of_month = out_reg.day_of_month;
    assign m_hour         = out_reg.hour;
    assign m_minute       = out_reg.minute;
    assign m_second       = out_reg.second;
    assign m_weekday      = out_reg.weekday;
    assign m_day_of_year  = out_reg.day_of_year;

endmodule

@@ test/tb_epoch_seconds_to_civil_date.sv @@
module tb_epoch_seconds_to_civil_date;

    localparam int SECONDS_W = e2cd_pkg::SECONDS_WIDTH_DEFAULT;

    localparam longint SECS_PER_DAY      = 86400;
    localparam longint DAYS_BEFORE_EPOCH = 719468;  // 0000-03-01 .. 1970-01-01
    localparam longint DAYS_PER_ERA      = 146097;

    localparam int RANDOM_WORDS   = 1330;
    localparam int LONG_STALL     = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 1000000;

    logic                                 aclk = 1'b0;
    logic                                 aresetn;
    logic                                 s_valid;
    logic                                 s_ready;
    logic signed [SECONDS_W-1:0]          s_epoch_seconds;
    logic                                 m_valid;
    logic                                 m_ready;
    logic signed [e2cd_pkg::YEAR_W-1:0]   m_year;
    logic [e2cd_pkg::MONTH_W-1:0]         m_month;
    logic [e2cd_pkg::MDAY_W-1:0]          m_day_of_month;
    logic [e2cd_pkg::HOUR_W-1:0]          m_hour;
    logic [e2cd_pkg::MINUTE_W-1:0]        m_minute;
    logic [e2cd_pkg::SECOND_W-1:0]        m_second;
    logic [e2cd_pkg::WEEKDAY_W-1:0]       m_weekday;
    logic [e2cd_pkg::YDAY_W-1:0]          m_day_of_year;

    e2cd_pkg::result_t pending_dates[$];
    int      mismatches = 0;
    bit      steady = 1'b0;
    bit      long_stall_req = 1'b0;
    int      cycle_count = 0;

    // Directed table: seconds, whether the date is typed in, and the typed date.
    logic signed [SECONDS_W-1:0] row_secs[$];
    bit                          row_known[$];
    e2cd_pkg::result_t           row_date[$];

    epoch_seconds_to_civil_date #(
        .SECONDS_WIDTH(SECONDS_W)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_epoch_seconds(s_epoch_seconds),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_year(m_year),
        .m_month(m_month),
        .m_day_of_month(m_day_of_month),
        .m_hour(m_hour),
        .m_minute(m_minute),
        .m_second(m_second),
        .m_weekday(m_weekday),
        .m_day_of_year(m_day_of_year)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic e2cd_pkg::result_t civil_date_of(
        input logic signed [SECONDS_W-1:0] secs
    );
        longint t, days, tod, era, eday, eyear, yday, mp, mday, mon, doy, yr, wd;
        bit     leap;
        e2cd_pkg::result_t r;
        t = longint'(secs);
        days = t / SECS_PER_DAY;
        if (t % SECS_PER_DAY != 0 && t < 0) begin
            days = days - 1;
        end
        tod = t - days * SECS_PER_DAY;
        days = days + DAYS_BEFORE_EPOCH;
        wd = (days + 3) % 7;
        if (wd < 0) begin
            wd = wd + 7;
        end
        era = days / DAYS_PER_ERA;
        if (days % DAYS_PER_ERA != 0 && days < 0) begin
            era = era - 1;
        end
        eday = days - era * DAYS_PER_ERA;
        eyear = (eday - eday / 1460 + eday / 36524 - eday / 146096) / 365;
        yday = eday - (365 * eyear + eyear / 4 - eyear / 100);
        mp = (5 * yday + 2) / 153;
        mday = yday - (153 * mp + 2) / 5 + 1;
        mon = (mp < 10) ? mp + 2 : mp - 10;
        leap = ((eyear % 4 == 0) && (eyear % 100 != 0)) || (eyear % 400 == 0);
        // The March-based year runs into January and February of the next civil year.
        doy = (yday >= 306) ? yday - 306 : yday + 59 + longint'(leap);
        yr = eyear + era * 400 + ((mon <= 1) ? 1 : 0);
        r.year         = yr[e2cd_pkg::YEAR_W-1:0];
        r.month        = mon[e2cd_pkg::MONTH_W-1:0];
        r.day_of_month = mday[e2cd_pkg::MDAY_W-1:0];
        r.hour         = 5'(tod / 3600);
        r.minute       = 6'((tod % 3600) / 60);
        r.second       = 6'(tod % 60);
        r.weekday      = wd[e2cd_pkg::WEEKDAY_W-1:0];
        r.day_of_year  = doy[e2cd_pkg::YDAY_W-1:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 70) begin
            return 0;
        end else if (r < 95) begin
            return int'($urandom_range(1, 3));
        end
        return int'($urandom_range(10, 40));
    endfunction

    function automatic logic signed [SECONDS_W-1:0] pick_seconds();
        longint k, y, off, day, sec;
        int     kind;
        kind = int'($urandom_range(0, 99));
        if (kind < 30) begin
            return SECONDS_W'({$urandom, $urandom});
        end else if (kind < 45) begin
            return SECONDS_W'($signed($urandom));
        end else if (kind < 60) begin
            // Around midnight of a random day.
            day = longint'($urandom_range(0, 12000000)) - 6000000;
            return SECONDS_W'(day * SECS_PER_DAY + longint'($urandom_range(0, 2)) - 1);
        end
        // Around March 1 or January 1, or on a random day, of a chosen year of an era.
        k = longint'($urandom_range(0, 84)) - 37;
        case ($urandom_range(0, 3))
            0: y = longint'($urandom_range(0, 3)) * 100;
            1: y = longint'($urandom_range(0, 1)) * 399;
            default: y = longint'($urandom_range(0, 399));
        endcase
        case ($urandom_range(0, 6))
            0: off = -1;
            1: off = 0;
            2: off = 1;
            3: off = 305;
            4: off = 306;
            5: off = 307;
            default: off = longint'($urandom_range(0, 365));
        endcase
        case ($urandom_range(0, 2))
            0: sec = 0;
            1: sec = SECS_PER_DAY - 1;
            default: sec = longint'($urandom_range(0, 32'(SECS_PER_DAY - 1)));
        endcase
        day = k * DAYS_PER_ERA + 365 * y + y / 4 - y / 100 - DAYS_BEFORE_EPOCH + off;
        return SECONDS_W'(day * SECS_PER_DAY + sec);
    endfunction

    task automatic add_known(input longint secs, input int yr, input int mon, input int mday,
                             input int hr, input int mi, input int sc, input int wd,
                             input int doy);
        e2cd_pkg::result_t r;
        r.year = yr[e2cd_pkg::YEAR_W-1:0];
        r.month = mon[e2cd_pkg::MONTH_W-1:0];
        r.day_of_month = mday[e2cd_pkg::MDAY_W-1:0];
        r.hour = hr[e2cd_pkg::HOUR_W-1:0];
        r.minute = mi[e2cd_pkg::MINUTE_W-1:0];
        r.second = sc[e2cd_pkg::SECOND_W-1:0];
        r.weekday = wd[e2cd_pkg::WEEKDAY_W-1:0];
        r.day_of_year = doy[e2cd_pkg::YDAY_W-1:0];
        row_secs.push_back(secs[SECONDS_W-1:0]);
        row_known.push_back(1'b1);
        row_date.push_back(r);
    endtask

    task automatic add_checked(input longint secs);
        row_secs.push_back(secs[SECONDS_W-1:0]);
        row_known.push_back(1'b0);
        row_date.push_back('0);
    endtask

    // Offers one word, waits for it to be taken, then idles for the given gap.
    task automatic send_word(input logic signed [SECONDS_W-1:0] secs,
                             input e2cd_pkg::result_t date, input int gap);
        s_valid <= 1'b1;
        s_epoch_seconds <= secs;
        do @(posedge aclk); while (!s_ready);
        pending_dates.push_back(date);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic note_mismatch(input string what, input e2cd_pkg::result_t want,
                                 input e2cd_pkg::result_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $write("%s: expected %0d-%0d-%0d %0d:%0d:%0d wd %0d yd %0d, ",
                   what, $signed(want.year), want.month, want.day_of_month, want.hour,
                   want.minute, want.second, want.weekday, want.day_of_year);
            $display("got %0d-%0d-%0d %0d:%0d:%0d wd %0d yd %0d",
                     $signed(got.year), got.month, got.day_of_month, got.hour,
                     got.minute, got.second, got.weekday, got.day_of_year);
        end
    endtask

    always @(posedge aclk) begin : watch_results
        e2cd_pkg::result_t got;
        e2cd_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.year = m_year;
            got.month = m_month;
            got.day_of_month = m_day_of_month;
            got.hour = m_hour;
            got.minute = m_minute;
            got.second = m_second;
            got.weekday = m_weekday;
            got.day_of_year = m_day_of_year;
            if (pending_dates.size() == 0) begin
                note_mismatch("unexpected word", '0, got);
            end else begin
                want = pending_dates.pop_front();
                if (got.year != want.year || got.month != want.month
                        || got.day_of_month != want.day_of_month || got.hour != want.hour
                        || got.minute != want.minute || got.second != want.second
                        || got.weekday != want.weekday
                        || got.day_of_year != want.day_of_year) begin
                    note_mismatch("mismatch", want, got);
                end
            end
        end
    end

    initial begin
        int gap;
        m_ready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (long_stall_req) begin
                // Hold off long enough for the pipeline and the skid register to fill.
                m_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
                long_stall_req = 1'b0;
            end else begin
                gap = steady ? 0 : pick_gap();
                if (gap == 0) begin
                    m_ready <= 1'b1;
                    @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[epoch_seconds_to_civil_date] ERROR");
        $finish;
    end

    initial begin
        logic signed [SECONDS_W-1:0] secs;
        int gap;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_epoch_seconds = '0;

        add_known(64'sd0, 1970, 0, 1, 0, 0, 0, 4, 0);
        add_known(-64'sd1, 1969, 11, 31, 23, 59, 59, 3, 364);
        add_known(64'sd86400, 1970, 0, 2, 0, 0, 0, 5, 1);
        add_known(64'sd951782400, 2000, 1, 29, 0, 0, 0, 2, 59);
        add_known(64'sd978307199, 2000, 11, 31, 23, 59, 59, 0, 365);
        add_checked(64'sd549755813887);
        add_checked(-64'sd549755813888);
        add_checked(64'sd86399);
        add_checked(-64'sd86400);
        add_checked(-64'sd86401);
        add_checked(64'sd3599);
        add_checked(64'sd43200);
        add_checked(64'sd2147483647);
        add_checked(64'sd2147483648);
        add_checked(-64'sd2147483648);
        add_checked(-64'sd62162035200);
        add_checked(-64'sd62162035201);
        add_checked(-64'sd62135596800);
        add_checked(-64'sd2208988800);
        add_checked(-64'sd2203891200);
        add_checked(64'sd4107542400);
        add_checked(64'sd253402300799);
        add_checked(64'sd12622780800);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (row_secs[i]) begin
            send_word(row_secs[i], row_known[i] ? row_date[i] : civil_date_of(row_secs[i]),
                      pick_gap());
        end

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i % 150 == 0) begin
                steady = ~steady;
            end
            if (i == 300) begin
                long_stall_req = 1'b1;
            end
            secs = pick_seconds();
            // Keep the input busy while the receiver is held off.
            gap = (steady || (i >= 300 && i < 380)) ? 0 : pick_gap();
            if (i == 700) begin
                send_word(secs, civil_date_of(secs), 1);
                while (pending_dates.size() != 0) @(posedge aclk);
            end else begin
                send_word(secs, civil_date_of(secs), gap);
            end
        end
        s_valid <= 1'b0;

        while (pending_dates.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[epoch_seconds_to_civil_date] OK");
        end else begin
            $display("[epoch_seconds_to_civil_date] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/e2cd_pkg.sv
hw/rtl/epoch_seconds_to_civil_date.sv
test/tb_epoch_seconds_to_civil_date.sv
